FILE: rtl/vfs_pkg.sv
// Package: grid geometry, operation codes and row helpers for the voxel face scanner.
`timescale 1ns / 1ps
package vfs_pkg;
    localparam int GRID_SIZE = 16;
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int ROWS      = GRID_SIZE * GRID_SIZE;
    localparam int RW        = 2 * CW;
    localparam int HW        = 7;

    typedef logic [GRID_SIZE-1:0] t_row;
    typedef logic [RW-1:0]        t_row_addr;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_FILL  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;
    localparam logic [1:0] FN_SCAN  = 2'd3;

    function automatic t_row zmask_from(input logic [CW-1:0] zs);
        zmask_from = {GRID_SIZE{1'b1}} << zs;
    endfunction
endpackage

FILE: rtl/voxel_visible_face_scanner.sv
// Voxel occupancy grid with write, terrain fill, read and visible-face scan.
// Write/read: a row read, then write-back (S_RMW) or bit pick (S_RD). Fill answers from idle.
// Scan: a grid row without a solid voxel past the cursor is passed over in S_SC_C; a row
// examined then reads four neighbor rows through the single memory read port (S_SC_N)
// and S_SC_E picks the visible voxel. The receiver cannot stall; busy is high out of S_IDLE.
// Reset (synchronous) clears all row valid bits, so the grid reads empty at once.
`timescale 1ns / 1ps
module voxel_visible_face_scanner (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_func,
    input  logic [vfs_pkg::CW-1:0]  i_voxel_x,
    input  logic [vfs_pkg::CW-1:0]  i_voxel_y,
    input  logic [vfs_pkg::CW-1:0]  i_voxel_z,
    input  logic                    i_solid_in,
    input  logic [7:0]              i_terrain_height,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [vfs_pkg::CW-1:0]  o_face_x,
    output logic [vfs_pkg::CW-1:0]  o_face_y,
    output logic [vfs_pkg::CW-1:0]  o_face_z,
    output logic [5:0]              o_face_mask,
    output logic                    o_solid_out,
    output logic                    o_mesh_dirty
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SC_C = 3'd3;
    localparam logic [2:0] S_SC_N = 3'd4;
    localparam logic [2:0] S_SC_E = 3'd5;

    localparam int CURW = 3 * vfs_pkg::CW + 1;
    localparam logic [vfs_pkg::CW-1:0] CMAX = {vfs_pkg::CW{1'b1}};
    localparam vfs_pkg::t_row_addr RMAX = {vfs_pkg::RW{1'b1}};

    vfs_pkg::t_row          mem [vfs_pkg::ROWS];
    logic [vfs_pkg::ROWS-1:0] r_vld;
    vfs_pkg::t_row          r_mq;
    logic                   r_vq, r_bq, r_oq;

    logic [2:0]             r_state, n_state;
    logic [CURW-1:0]        r_cur, n_cur;
    logic                   r_dirty, n_dirty;
    logic [vfs_pkg::HW-1:0] r_half, n_half;
    vfs_pkg::t_row_addr     r_row, n_row;
    logic [vfs_pkg::CW-1:0] r_zs, n_zs;
    logic                   r_solid, n_solid;
    logic [1:0]             r_k, n_k;
    vfs_pkg::t_row          r_c, n_c;
    vfs_pkg::t_row          r_nb [4];

    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [vfs_pkg::CW-1:0] r_fx, n_fx, r_fy, n_fy, r_fz, n_fz;
    logic [5:0]             r_mask, n_mask;
    logic                   r_sout, n_sout;

    vfs_pkg::t_row_addr     rd_addr;
    logic                   rd_oob;
    logic                   we;
    vfs_pkg::t_row          wdata;
    logic                   vclr;
    logic                   nb_we;

    vfs_pkg::t_row          row_val;
    vfs_pkg::t_row          cpz, cmz, vis, zm;
    logic [5:0]             fm [vfs_pkg::GRID_SIZE];
    logic [vfs_pkg::CW-1:0] hit_z;
    logic [vfs_pkg::CW-1:0] rx, ry;

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_face_x     = r_fx;
    assign o_face_y     = r_fy;
    assign o_face_z     = r_fz;
    assign o_face_mask  = r_mask;
    assign o_solid_out  = r_sout;
    assign o_mesh_dirty = r_dirty;

    assign row_val = r_oq ? '0 : (r_vq ? r_mq : (r_bq ? '1 : '0));
    assign rx      = r_row[vfs_pkg::RW-1:vfs_pkg::CW];
    assign ry      = r_row[vfs_pkg::CW-1:0];

    always_comb begin
        cpz = {1'b0, r_c[vfs_pkg::GRID_SIZE-1:1]};
        cmz = {r_c[vfs_pkg::GRID_SIZE-2:0], 1'b0};
        zm  = vfs_pkg::zmask_from(r_zs);
        for (int z = 0; z < vfs_pkg::GRID_SIZE; z++) begin
            fm[z]  = {~cmz[z], ~cpz[z], ~r_nb[3][z], ~r_nb[2][z], ~r_nb[1][z], ~r_nb[0][z]};
            vis[z] = r_c[z] & zm[z] & (|fm[z]);
        end
        hit_z = '0;
        for (int z = vfs_pkg::GRID_SIZE - 1; z >= 0; z--) begin
            if (vis[z]) begin
                hit_z = vfs_pkg::CW'(z);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_dirty = r_dirty;
        n_half  = r_half;
        n_row   = r_row;
        n_zs    = r_zs;
        n_solid = r_solid;
        n_k     = r_k;
        n_c     = r_c;
        n_valid = 1'b0;
        n_found = r_found;
        n_fx    = r_fx;
        n_fy    = r_fy;
        n_fz    = r_fz;
        n_mask  = r_mask;
        n_sout  = r_sout;
        rd_addr = r_row;
        rd_oob  = 1'b0;
        we      = 1'b0;
        wdata   = row_val;
        vclr    = 1'b0;
        nb_we   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_found = 1'b0;
                    n_fx    = '0;
                    n_fy    = '0;
                    n_fz    = '0;
                    n_mask  = '0;
                    n_sout  = 1'b0;
                    case (i_func)
                        vfs_pkg::FN_WRITE, vfs_pkg::FN_READ: begin
                            rd_addr = {i_voxel_x, i_voxel_y};
                            n_row   = {i_voxel_x, i_voxel_y};
                            n_zs    = i_voxel_z;
                            n_solid = i_solid_in;
                            n_state = (i_func == vfs_pkg::FN_WRITE) ? S_RMW : S_RD;
                        end
                        vfs_pkg::FN_FILL: begin
                            n_half  = i_terrain_height[7:1];
                            vclr    = 1'b1;
                            n_dirty = 1'b1;
                            n_valid = 1'b1;
                        end
                        default: begin
                            if (r_cur[CURW-1]) begin
                                n_cur   = '0;
                                n_dirty = 1'b0;
                                n_valid = 1'b1;
                            end else begin
                                rd_addr = r_cur[CURW-2:vfs_pkg::CW];
                                n_row   = r_cur[CURW-2:vfs_pkg::CW];
                                n_zs    = r_cur[vfs_pkg::CW-1:0];
                                n_state = S_SC_C;
                            end
                        end
                    endcase
                end
            end
            S_RMW: begin
                we      = 1'b1;
                wdata   = row_val;
                wdata[r_zs] = r_solid;
                n_dirty = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                n_sout  = row_val[r_zs];
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SC_C: begin
                n_c = row_val;
                if ((row_val & vfs_pkg::zmask_from(r_zs)) == '0) begin
                    if (r_row == RMAX) begin
                        n_cur   = '0;
                        n_dirty = 1'b0;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_zs    = '0;
                        rd_addr = r_row + 1'b1;
                    end
                end else begin
                    rd_addr = {rx + 1'b1, ry};
                    rd_oob  = (rx == CMAX);
                    n_k     = 2'd0;
                    n_state = S_SC_N;
                end
            end
            S_SC_N: begin
                nb_we = 1'b1;
                case (r_k)
                    2'd0: begin
                        rd_addr = {rx - 1'b1, ry};
                        rd_oob  = (rx == '0);
                    end
                    2'd1: begin
                        rd_addr = {rx, ry + 1'b1};
                        rd_oob  = (ry == CMAX);
                    end
                    2'd2: begin
                        rd_addr = {rx, ry - 1'b1};
                        rd_oob  = (ry == '0);
                    end
                    default: begin
                        rd_addr = r_row;
                    end
                endcase
                n_k = r_k + 1'b1;
                if (r_k == 2'd3) begin
                    n_state = S_SC_E;
                end
            end
            S_SC_E: begin
                if (vis != '0) begin
                    n_found = 1'b1;
                    n_fx    = rx;
                    n_fy    = ry;
                    n_fz    = hit_z;
                    n_mask  = fm[hit_z];
                    n_cur   = {1'b0, r_row, hit_z} + 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_row == RMAX) begin
                    n_cur   = '0;
                    n_dirty = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_zs    = '0;
                    rd_addr = r_row + 1'b1;
                    n_state = S_SC_C;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_row] <= wdata;
        end
        r_mq <= mem[rd_addr];
        r_vq <= r_vld[rd_addr];
        r_bq <= ({3'b000, rd_addr[vfs_pkg::CW-1:0]} < r_half);
        r_oq <= rd_oob;
        if (nb_we) begin
            r_nb[r_k] <= row_val;
        end
        r_row   <= n_row;
        r_zs    <= n_zs;
        r_solid <= n_solid;
        r_k     <= n_k;
        r_c     <= n_c;
        r_found <= n_found;
        r_fx    <= n_fx;
        r_fy    <= n_fy;
        r_fz    <= n_fz;
        r_mask  <= n_mask;
        r_sout  <= n_sout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_dirty <= 1'b1;
            r_half  <= '0;
            r_valid <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_dirty <= n_dirty;
            r_half  <= n_half;
            r_valid <= n_valid;
            if (vclr) begin
                r_vld <= '0;
            end else if (we) begin
                r_vld[r_row] <= 1'b1;
            end
        end
    end
endmodule

FILE: rtl/vfs_checker.sv
// Port-level checker for the voxel face scanner, bound to the top level.
`timescale 1ns / 1ps
module vfs_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              i_func,
    input  logic                    o_valid,
    input  logic                    o_found,
    input  logic [vfs_pkg::CW-1:0]  o_face_x,
    input  logic [vfs_pkg::CW-1:0]  o_face_y,
    input  logic [vfs_pkg::CW-1:0]  o_face_z,
    input  logic [5:0]              o_face_mask,
    input  logic                    o_solid_out,
    input  logic                    o_mesh_dirty
);
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_fill_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == vfs_pkg::FN_FILL) |=> (o_valid && o_mesh_dirty))
        else $error("terrain fill did not return a dirty result next cycle");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
        (o_face_mask == '0 && o_face_x == '0 && o_face_y == '0 && o_face_z == '0))
        else $error("face fields not zero without a found voxel");

    a_found_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_face_mask != '0 && !o_solid_out))
        else $error("found voxel without exposed face");
endmodule

bind voxel_visible_face_scanner vfs_checker u_vfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_face_x     (o_face_x),
    .o_face_y     (o_face_y),
    .o_face_z     (o_face_z),
    .o_face_mask  (o_face_mask),
    .o_solid_out  (o_solid_out),
    .o_mesh_dirty (o_mesh_dirty)
);

FILE: verif/tb_top.sv
// Testbench for the voxel face scanner: queued item driver, result monitor and grid predictor.
`timescale 1ns / 1ps
module tb_top;
    localparam int TOTAL_VOXELS    = vfs_pkg::GRID_SIZE * vfs_pkg::GRID_SIZE *
                                     vfs_pkg::GRID_SIZE;
    localparam int TERRAIN_DIVISOR = 2;
    localparam int RANDOM_ITEMS    = 1450;
    localparam int IDLE_PERCENT    = 21;
    localparam int STEADY_FIRST    = 400;
    localparam int STEADY_LAST     = 700;
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTED    = 200;

    typedef struct packed {
        logic [1:0]             func;
        logic [vfs_pkg::CW-1:0] x;
        logic [vfs_pkg::CW-1:0] y;
        logic [vfs_pkg::CW-1:0] z;
        logic                   solid;
        logic [7:0]             height;
    } t_vox_cmd;

    typedef struct packed {
        logic                   found;
        logic [vfs_pkg::CW-1:0] x;
        logic [vfs_pkg::CW-1:0] y;
        logic [vfs_pkg::CW-1:0] z;
        logic [5:0]             mask;
        logic                   solid;
        logic                   dirty;
    } t_face_report;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_func;
    logic [vfs_pkg::CW-1:0] i_voxel_x;
    logic [vfs_pkg::CW-1:0] i_voxel_y;
    logic [vfs_pkg::CW-1:0] i_voxel_z;
    logic                   i_solid_in;
    logic [7:0]             i_terrain_height;
    logic                   o_valid;
    logic                   o_found;
    logic [vfs_pkg::CW-1:0] o_face_x;
    logic [vfs_pkg::CW-1:0] o_face_y;
    logic [vfs_pkg::CW-1:0] o_face_z;
    logic [5:0]             o_face_mask;
    logic                   o_solid_out;
    logic                   o_mesh_dirty;

    voxel_visible_face_scanner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_voxel_x        (i_voxel_x),
        .i_voxel_y        (i_voxel_y),
        .i_voxel_z        (i_voxel_z),
        .i_solid_in       (i_solid_in),
        .i_terrain_height (i_terrain_height),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_face_x         (o_face_x),
        .o_face_y         (o_face_y),
        .o_face_z         (o_face_z),
        .o_face_mask      (o_face_mask),
        .o_solid_out      (o_solid_out),
        .o_mesh_dirty     (o_mesh_dirty)
    );

    vfs_pkg::t_row model_grid [vfs_pkg::ROWS];
    int            model_cursor;
    logic          model_dirty;

    t_vox_cmd      cmd_queue [$];
    t_face_report  face_reports_due [$];
    int            items_queued;
    int            items_sent;
    int            items_accepted;
    bit            item_taken;
    int            stall_cycles;
    int            mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic grid_solid(int x, int y, int z);
        if (x < 0 || x >= vfs_pkg::GRID_SIZE || y < 0 || y >= vfs_pkg::GRID_SIZE ||
            z < 0 || z >= vfs_pkg::GRID_SIZE) begin
            return 1'b0;
        end
        return model_grid[vfs_pkg::t_row_addr'(x * vfs_pkg::GRID_SIZE + y)]
                         [z[vfs_pkg::CW-1:0]];
    endfunction

    function automatic logic [5:0] exposed_mask(int x, int y, int z);
        logic [5:0] m;
        m[0] = !grid_solid(x + 1, y, z);
        m[1] = !grid_solid(x - 1, y, z);
        m[2] = !grid_solid(x, y + 1, z);
        m[3] = !grid_solid(x, y - 1, z);
        m[4] = !grid_solid(x, y, z + 1);
        m[5] = !grid_solid(x, y, z - 1);
        return m;
    endfunction

    function automatic t_face_report predict_face_report(t_vox_cmd cmd);
        t_face_report rep;
        int           half;
        int           i;
        int           gx;
        int           gy;
        int           gz;
        logic [5:0]   m;
        rep = '0;
        case (cmd.func)
            vfs_pkg::FN_WRITE: begin
                model_grid[{cmd.x, cmd.y}][cmd.z] = cmd.solid;
                model_dirty = 1'b1;
            end
            vfs_pkg::FN_FILL: begin
                half = int'(cmd.height) / TERRAIN_DIVISOR;
                for (int r = 0; r < vfs_pkg::ROWS; r++) begin
                    model_grid[vfs_pkg::t_row_addr'(r)] =
                        ((r % vfs_pkg::GRID_SIZE) < half) ? '1 : '0;
                end
                model_dirty = 1'b1;
            end
            vfs_pkg::FN_READ: begin
                rep.solid = grid_solid(int'(cmd.x), int'(cmd.y), int'(cmd.z));
            end
            default: begin
                i = (model_cursor < TOTAL_VOXELS) ? model_cursor : TOTAL_VOXELS;
                while (i < TOTAL_VOXELS && !rep.found) begin
                    gx = i / (vfs_pkg::GRID_SIZE * vfs_pkg::GRID_SIZE);
                    gy = (i / vfs_pkg::GRID_SIZE) % vfs_pkg::GRID_SIZE;
                    gz = i % vfs_pkg::GRID_SIZE;
                    m  = grid_solid(gx, gy, gz) ? exposed_mask(gx, gy, gz) : 6'd0;
                    if (m != 6'd0) begin
                        rep.found = 1'b1;
                        rep.x     = gx[vfs_pkg::CW-1:0];
                        rep.y     = gy[vfs_pkg::CW-1:0];
                        rep.z     = gz[vfs_pkg::CW-1:0];
                        rep.mask  = m;
                    end else begin
                        i++;
                    end
                end
                if (rep.found) begin
                    model_cursor = i + 1;
                end else begin
                    model_cursor = 0;
                    model_dirty  = 1'b0;
                end
            end
        endcase
        rep.dirty = model_dirty;
        return rep;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic queue_cmd(logic [1:0] f, int x, int y, int z, int s, int h);
        t_vox_cmd c;
        c.func   = f;
        c.x      = x[vfs_pkg::CW-1:0];
        c.y      = y[vfs_pkg::CW-1:0];
        c.z      = z[vfs_pkg::CW-1:0];
        c.solid  = s[0];
        c.height = h[7:0];
        cmd_queue.insert(cmd_queue.size(), c);
        items_queued++;
    endtask

    task automatic wait_all_done();
        while (items_accepted != items_queued || face_reports_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_random_cmds(int count);
        int stop;
        int pick;
        int n;
        int bx;
        int by;
        int bz;
        int lx;
        int ly;
        int lz;
        stop = items_queued + count;
        lx   = 0;
        ly   = 0;
        lz   = 0;
        while (items_queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_cmd(vfs_pkg::FN_FILL, 0, 0, 0, 0, ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, 255) : $urandom_range(0, 3));
            end else if (pick < 13) begin
                // build a 3x3x3 cube on an empty grid, then scan it to the end
                bx = $urandom_range(0, vfs_pkg::GRID_SIZE - 3);
                by = $urandom_range(0, vfs_pkg::GRID_SIZE - 3);
                bz = $urandom_range(0, vfs_pkg::GRID_SIZE - 3);
                queue_cmd(vfs_pkg::FN_FILL, 0, 0, 0, 0, $urandom_range(0, 1));
                for (int dx = 0; dx < 3; dx++) begin
                    for (int dy = 0; dy < 3; dy++) begin
                        for (int dz = 0; dz < 3; dz++) begin
                            queue_cmd(vfs_pkg::FN_WRITE, bx + dx, by + dy, bz + dz, 1,
                                      $urandom_range(0, 255));
                        end
                    end
                end
                if ($urandom_range(0, 1) == 0) begin
                    queue_cmd(vfs_pkg::FN_WRITE, bx, by, bz, 0, $urandom_range(0, 255));
                end
                repeat (28) queue_cmd(vfs_pkg::FN_SCAN, $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom_range(0, 15),
                                      $urandom_range(0, 1), $urandom_range(0, 255));
            end else if (pick < 45) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0) begin
                        lx = (lx + $urandom_range(0, 2) + vfs_pkg::GRID_SIZE - 1) %
                             vfs_pkg::GRID_SIZE;
                        ly = (ly + $urandom_range(0, 2) + vfs_pkg::GRID_SIZE - 1) %
                             vfs_pkg::GRID_SIZE;
                        lz = (lz + $urandom_range(0, 2) + vfs_pkg::GRID_SIZE - 1) %
                             vfs_pkg::GRID_SIZE;
                    end else begin
                        lx = $urandom_range(0, 15);
                        ly = $urandom_range(0, 15);
                        lz = $urandom_range(0, 15);
                    end
                    queue_cmd(vfs_pkg::FN_WRITE, lx, ly, lz,
                              int'($urandom_range(0, 3) != 0), $urandom_range(0, 255));
                end
            end else if (pick < 60) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0) begin
                        queue_cmd(vfs_pkg::FN_READ, lx, ly, lz, $urandom_range(0, 1),
                                  $urandom_range(0, 255));
                    end else begin
                        queue_cmd(vfs_pkg::FN_READ, $urandom_range(0, 15),
                                  $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 1), $urandom_range(0, 255));
                    end
                end
            end else if (pick < 90) begin
                n = $urandom_range(1, 30);
                repeat (n) queue_cmd(vfs_pkg::FN_SCAN, $urandom_range(0, 15),
                                     $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 1), $urandom_range(0, 255));
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 15),
                                     $urandom_range(0, 15), $urandom_range(0, 15),
                                     $urandom_range(0, 1), $urandom_range(0, 255));
            end
        end
    endtask

    always @(negedge i_clk) begin : drive_proc
        t_vox_cmd nxt;
        bit       steady;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            item_taken = 1'b0;
            steady     = items_sent >= STEADY_FIRST && items_sent < STEADY_LAST;
            if (cmd_queue.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                nxt = cmd_queue.pop_front();
                items_sent++;
                start            <= 1'b1;
                i_func           <= nxt.func;
                i_voxel_x        <= nxt.x;
                i_voxel_y        <= nxt.y;
                i_voxel_z        <= nxt.z;
                i_solid_in       <= nxt.solid;
                i_terrain_height <= nxt.height;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        t_face_report got;
        t_face_report want;
        t_vox_cmd     taken;
        if (i_rst_n) begin
            if (o_valid) begin
                got = {o_found, o_face_x, o_face_y, o_face_z, o_face_mask,
                       o_solid_out, o_mesh_dirty};
                if (face_reports_due.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = face_reports_due.pop_front();
                    check_field("found", 32'(got.found), 32'(want.found));
                    check_field("face_x", 32'(got.x), 32'(want.x));
                    check_field("face_y", 32'(got.y), 32'(want.y));
                    check_field("face_z", 32'(got.z), 32'(want.z));
                    check_field("face_mask", 32'(got.mask), 32'(want.mask));
                    check_field("solid_out", 32'(got.solid), 32'(want.solid));
                    check_field("mesh_dirty", 32'(got.dirty), 32'(want.dirty));
                end
            end
            if (start && !busy) begin
                taken = {i_func, i_voxel_x, i_voxel_y, i_voxel_z, i_solid_in,
                         i_terrain_height};
                face_reports_due.insert(face_reports_due.size(),
                                        predict_face_report(taken));
                item_taken = 1'b1;
                items_accepted++;
            end
            if (o_valid || (start && !busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_func           = vfs_pkg::FN_READ;
        i_voxel_x        = '0;
        i_voxel_y        = '0;
        i_voxel_z        = '0;
        i_solid_in       = 1'b0;
        i_terrain_height = '0;
        foreach (model_grid[r]) model_grid[r] = '0;
        model_cursor   = 0;
        model_dirty    = 1'b1;
        items_queued   = 0;
        items_sent     = 0;
        items_accepted = 0;
        item_taken     = 1'b0;
        stall_cycles   = 0;
        mismatches     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_READ, 15, 15, 15, 1, 255);
        queue_cmd(vfs_pkg::FN_WRITE, 0, 0, 0, 1, 0);
        queue_cmd(vfs_pkg::FN_WRITE, 15, 15, 15, 1, 255);
        queue_cmd(vfs_pkg::FN_READ, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_READ, 15, 15, 15, 0, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 15, 15, 15, 1, 255);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_WRITE, 15, 15, 15, 0, 0);
        queue_cmd(vfs_pkg::FN_WRITE, 0, 0, 0, 1, 0);
        queue_cmd(vfs_pkg::FN_READ, 15, 15, 15, 0, 0);
        queue_cmd(vfs_pkg::FN_FILL, 0, 0, 0, 0, 255);
        queue_cmd(vfs_pkg::FN_READ, 7, 7, 7, 0, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_FILL, 15, 15, 15, 1, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_FILL, 0, 0, 0, 0, 2);
        queue_cmd(vfs_pkg::FN_READ, 3, 0, 9, 0, 0);
        queue_cmd(vfs_pkg::FN_READ, 3, 1, 9, 0, 0);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        queue_cmd(vfs_pkg::FN_FILL, 0, 0, 0, 0, 1);
        queue_cmd(vfs_pkg::FN_SCAN, 0, 0, 0, 0, 0);
        wait_all_done();

        queue_random_cmds(RANDOM_ITEMS / 2);
        // hold new items until the grid has answered everything
        wait_all_done();
        queue_random_cmds(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
